// File: rtl/core/rvdec_pkg.sv
package rvdec_pkg;

    localparam int ADDR_BITS = 13;

    typedef enum logic [6:0] {
        M_NONE, M_LUI, M_AUIPC, M_JAL, M_JALR, M_BEQ, M_BNE, M_BLT, M_BGE, M_BLTU, M_BGEU,
        M_LB, M_LH, M_LW, M_LD, M_LBU, M_LHU, M_LWU, M_SB, M_SH, M_SW, M_SD,
        M_ADDI, M_SLTI, M_SLTIU, M_XORI, M_ORI, M_ANDI, M_SLLI, M_SRLI, M_SRAI,
        M_ADD, M_SUB, M_SLL, M_SLT, M_SLTU, M_XOR, M_SRL, M_SRA, M_OR, M_AND,
        M_ADDIW, M_SLLIW, M_SRLIW, M_SRAIW, M_ADDW, M_SUBW, M_SLLW, M_SRLW, M_SRAW,
        M_FENCE, M_FENCE_I, M_ECALL, M_EBREAK,
        M_CSRRW, M_CSRRS, M_CSRRC, M_CSRRWI, M_CSRRSI, M_CSRRCI,
        M_C_ADDI4SPN, M_C_LW, M_C_LD, M_C_SW, M_C_SD,
        M_C_NOP, M_C_ADDI, M_C_ADDIW, M_C_LI, M_C_ADDI16SP, M_C_LUI,
        M_C_SRLI, M_C_SRAI, M_C_ANDI, M_C_SUB, M_C_XOR, M_C_OR, M_C_AND, M_C_SUBW,
        M_C_ADDW, M_C_J, M_C_BEQZ, M_C_BNEZ,
        M_C_SLLI, M_C_LWSP, M_C_LDSP, M_C_JR, M_C_MV, M_C_EBREAK, M_C_JALR, M_C_ADD,
        M_C_SWSP, M_C_SDSP
    } mnem_t;

    localparam logic [6:0] OP_LUI    = 7'h37;
    localparam logic [6:0] OP_AUIPC  = 7'h17;
    localparam logic [6:0] OP_JAL    = 7'h6F;
    localparam logic [6:0] OP_JALR   = 7'h67;
    localparam logic [6:0] OP_BRANCH = 7'h63;
    localparam logic [6:0] OP_LOAD   = 7'h03;
    localparam logic [6:0] OP_STORE  = 7'h23;
    localparam logic [6:0] OP_IMM    = 7'h13;
    localparam logic [6:0] OP_IMM32  = 7'h1B;
    localparam logic [6:0] OP_REG    = 7'h33;
    localparam logic [6:0] OP_REG32  = 7'h3B;
    localparam logic [6:0] OP_FENCE  = 7'h0F;
    localparam logic [6:0] OP_SYSTEM = 7'h73;

    typedef struct packed {
        mnem_t       mn;
        logic [4:0]  rd;
        logic [4:0]  ra;
        logic [4:0]  rb;
        logic [31:0] imm;
    } dec_t;

endpackage

// File: rtl/core/rvdec_dec32.sv
module rvdec_dec32
    import rvdec_pkg::*;
(
    input  logic [31:0] w,
    output dec_t        d
);
    logic [6:0]  op;
    logic [4:0]  rd;
    logic [4:0]  rs1;
    logic [4:0]  rs2;
    logic [2:0]  f3;
    logic [6:0]  f7;
    logic [31:0] iimm;
    logic [31:0] simm;
    logic [31:0] bimm;
    logic [31:0] jimm;
    logic [31:0] uimm;
    logic [31:0] zhi;

    assign op   = w[6:0];
    assign rd   = w[11:7];
    assign f3   = w[14:12];
    assign rs1  = w[19:15];
    assign rs2  = w[24:20];
    assign f7   = w[31:25];
    assign iimm = {{20{w[31]}}, w[31:20]};
    assign simm = {{20{w[31]}}, w[31:25], w[11:7]};
    assign bimm = {{20{w[31]}}, w[7], w[30:25], w[11:8], 1'b0};
    assign jimm = {{12{w[31]}}, w[19:12], w[20], w[30:21], 1'b0};
    assign uimm = {w[31:12], 12'd0};
    assign zhi  = {20'd0, w[31:20]};

    always_comb
    begin
        d = '0;
        case (op)
            OP_LUI:   d = '{M_LUI, rd, 5'd0, 5'd0, uimm};
            OP_AUIPC: d = '{M_AUIPC, rd, 5'd0, 5'd0, uimm};
            OP_JAL:   d = '{M_JAL, rd, 5'd0, 5'd0, jimm};
            OP_JALR:
            begin
                if (f3 == 3'd0) d = '{M_JALR, rd, rs1, 5'd0, iimm};
            end
            OP_BRANCH:
            begin
                case (f3)
                    3'd0: d = '{M_BEQ, 5'd0, rs1, rs2, bimm};
                    3'd1: d = '{M_BNE, 5'd0, rs1, rs2, bimm};
                    3'd4: d = '{M_BLT, 5'd0, rs1, rs2, bimm};
                    3'd5: d = '{M_BGE, 5'd0, rs1, rs2, bimm};
                    3'd6: d = '{M_BLTU, 5'd0, rs1, rs2, bimm};
                    3'd7: d = '{M_BGEU, 5'd0, rs1, rs2, bimm};
                    default: d = '0;
                endcase
            end
            OP_LOAD:
            begin
                case (f3)
                    3'd0: d = '{M_LB, rd, rs1, 5'd0, iimm};
                    3'd1: d = '{M_LH, rd, rs1, 5'd0, iimm};
                    3'd2: d = '{M_LW, rd, rs1, 5'd0, iimm};
                    3'd3: d = '{M_LD, rd, rs1, 5'd0, iimm};
                    3'd4: d = '{M_LBU, rd, rs1, 5'd0, iimm};
                    3'd5: d = '{M_LHU, rd, rs1, 5'd0, iimm};
                    3'd6: d = '{M_LWU, rd, rs1, 5'd0, iimm};
                    default: d = '0;
                endcase
            end
            OP_STORE:
            begin
                case (f3)
                    3'd0: d = '{M_SB, 5'd0, rs1, rs2, simm};
                    3'd1: d = '{M_SH, 5'd0, rs1, rs2, simm};
                    3'd2: d = '{M_SW, 5'd0, rs1, rs2, simm};
                    3'd3: d = '{M_SD, 5'd0, rs1, rs2, simm};
                    default: d = '0;
                endcase
            end
            OP_IMM:
            begin
                case (f3)
                    3'd0: d = '{M_ADDI, rd, rs1, 5'd0, iimm};
                    3'd1:
                    begin
                        if (w[31:26] == 6'd0)
                            d = '{M_SLLI, rd, rs1, 5'd0, {26'd0, w[25:20]}};
                    end
                    3'd2: d = '{M_SLTI, rd, rs1, 5'd0, iimm};
                    3'd3: d = '{M_SLTIU, rd, rs1, 5'd0, iimm};
                    3'd4: d = '{M_XORI, rd, rs1, 5'd0, iimm};
                    3'd5:
                    begin
                        if (w[31:26] == 6'd0)
                            d = '{M_SRLI, rd, rs1, 5'd0, {26'd0, w[25:20]}};
                        else if (w[31:26] == 6'h10)
                            d = '{M_SRAI, rd, rs1, 5'd0, {26'd0, w[25:20]}};
                    end
                    3'd6: d = '{M_ORI, rd, rs1, 5'd0, iimm};
                    default: d = '{M_ANDI, rd, rs1, 5'd0, iimm};
                endcase
            end
            OP_IMM32:
            begin
                if (f3 == 3'd0)
                    d = '{M_ADDIW, rd, rs1, 5'd0, iimm};
                else if (f3 == 3'd1 && f7 == 7'd0)
                    d = '{M_SLLIW, rd, rs1, 5'd0, {27'd0, rs2}};
                else if (f3 == 3'd5 && f7 == 7'd0)
                    d = '{M_SRLIW, rd, rs1, 5'd0, {27'd0, rs2}};
                else if (f3 == 3'd5 && f7 == 7'h20)
                    d = '{M_SRAIW, rd, rs1, 5'd0, {27'd0, rs2}};
            end
            OP_REG:
            begin
                if (f7 == 7'd0)
                begin
                    case (f3)
                        3'd0: d = '{M_ADD, rd, rs1, rs2, 32'd0};
                        3'd1: d = '{M_SLL, rd, rs1, rs2, 32'd0};
                        3'd2: d = '{M_SLT, rd, rs1, rs2, 32'd0};
                        3'd3: d = '{M_SLTU, rd, rs1, rs2, 32'd0};
                        3'd4: d = '{M_XOR, rd, rs1, rs2, 32'd0};
                        3'd5: d = '{M_SRL, rd, rs1, rs2, 32'd0};
                        3'd6: d = '{M_OR, rd, rs1, rs2, 32'd0};
                        default: d = '{M_AND, rd, rs1, rs2, 32'd0};
                    endcase
                end
                else if (f7 == 7'h20 && f3 == 3'd0)
                    d = '{M_SUB, rd, rs1, rs2, 32'd0};
                else if (f7 == 7'h20 && f3 == 3'd5)
                    d = '{M_SRA, rd, rs1, rs2, 32'd0};
            end
            OP_REG32:
            begin
                if (f7 == 7'd0 && f3 == 3'd0) d = '{M_ADDW, rd, rs1, rs2, 32'd0};
                else if (f7 == 7'd0 && f3 == 3'd1) d = '{M_SLLW, rd, rs1, rs2, 32'd0};
                else if (f7 == 7'd0 && f3 == 3'd5) d = '{M_SRLW, rd, rs1, rs2, 32'd0};
                else if (f7 == 7'h20 && f3 == 3'd0) d = '{M_SUBW, rd, rs1, rs2, 32'd0};
                else if (f7 == 7'h20 && f3 == 3'd5) d = '{M_SRAW, rd, rs1, rs2, 32'd0};
            end
            OP_FENCE:
            begin
                if (f3 == 3'd0) d = '{M_FENCE, rd, rs1, 5'd0, zhi};
                else if (f3 == 3'd1) d = '{M_FENCE_I, rd, rs1, 5'd0, zhi};
            end
            OP_SYSTEM:
            begin
                case (f3)
                    3'd0:
                    begin
                        if (w == 32'h0000_0073) d = '{M_ECALL, 5'd0, 5'd0, 5'd0, 32'd0};
                        else if (w == 32'h0010_0073)
                            d = '{M_EBREAK, 5'd0, 5'd0, 5'd0, 32'd0};
                    end
                    3'd1: d = '{M_CSRRW, rd, rs1, 5'd0, zhi};
                    3'd2: d = '{M_CSRRS, rd, rs1, 5'd0, zhi};
                    3'd3: d = '{M_CSRRC, rd, rs1, 5'd0, zhi};
                    3'd5: d = '{M_CSRRWI, rd, rs1, 5'd0, zhi};
                    3'd6: d = '{M_CSRRSI, rd, rs1, 5'd0, zhi};
                    3'd7: d = '{M_CSRRCI, rd, rs1, 5'd0, zhi};
                    default: d = '0;
                endcase
            end
            default: d = '0;
        endcase
    end

endmodule

// File: rtl/core/rvdec_dec16.sv
module rvdec_dec16
    import rvdec_pkg::*;
(
    input  logic [15:0] c,
    output dec_t        d
);
    logic [2:0]  f3;
    logic        b12;
    logic [4:0]  r5;
    logic [4:0]  s5;
    logic [4:0]  rp1;
    logic [4:0]  rp2;
    logic [31:0] sh6;
    logic [31:0] imm6;
    logic [31:0] uw;
    logic [31:0] ud;
    logic [31:0] u4spn;
    logic [31:0] n16sp;
    logic [31:0] nlui;
    logic [31:0] nj;
    logic [31:0] nb;
    logic [31:0] ulwsp;
    logic [31:0] uldsp;
    logic [31:0] uswsp;
    logic [31:0] usdsp;

    assign f3    = c[15:13];
    assign b12   = c[12];
    assign r5    = c[11:7];
    assign s5    = c[6:2];
    assign rp1   = {2'b01, c[9:7]};
    assign rp2   = {2'b01, c[4:2]};
    assign sh6   = {26'd0, b12, s5};
    assign imm6  = {{26{b12}}, b12, s5};
    assign uw    = {25'd0, c[5], c[12:10], c[6], 2'd0};
    assign ud    = {24'd0, c[6:5], c[12:10], 3'd0};
    assign u4spn = {22'd0, c[10:7], c[12:11], c[5], c[6], 2'd0};
    assign n16sp = {{22{b12}}, b12, c[4:3], c[5], c[2], c[6], 4'd0};
    assign nlui  = {{14{b12}}, b12, s5, 12'd0};
    assign nj    = {{20{b12}}, b12, c[8], c[10:9], c[6], c[7], c[2], c[11], c[5:3], 1'b0};
    assign nb    = {{23{b12}}, b12, c[6:5], c[2], c[11:10], c[4:3], 1'b0};
    assign ulwsp = {24'd0, c[3:2], b12, c[6:4], 2'd0};
    assign uldsp = {23'd0, c[4:2], b12, c[6:5], 3'd0};
    assign uswsp = {24'd0, c[8:7], c[12:9], 2'd0};
    assign usdsp = {23'd0, c[9:7], c[12:10], 3'd0};

    always_comb
    begin
        d = '0;
        case (c[1:0])
            2'd0:
            begin
                case (f3)
                    3'd0:
                    begin
                        if (u4spn != 32'd0) d = '{M_C_ADDI4SPN, rp2, 5'd2, 5'd0, u4spn};
                    end
                    3'd2: d = '{M_C_LW, rp2, rp1, 5'd0, uw};
                    3'd3: d = '{M_C_LD, rp2, rp1, 5'd0, ud};
                    3'd6: d = '{M_C_SW, 5'd0, rp1, rp2, uw};
                    3'd7: d = '{M_C_SD, 5'd0, rp1, rp2, ud};
                    default: d = '0;
                endcase
            end
            2'd1:
            begin
                case (f3)
                    3'd0:
                    begin
                        if (r5 == 5'd0) d = '{M_C_NOP, 5'd0, 5'd0, 5'd0, imm6};
                        else d = '{M_C_ADDI, r5, r5, 5'd0, imm6};
                    end
                    3'd1:
                    begin
                        if (r5 != 5'd0) d = '{M_C_ADDIW, r5, r5, 5'd0, imm6};
                    end
                    3'd2: d = '{M_C_LI, r5, 5'd0, 5'd0, imm6};
                    3'd3:
                    begin
                        if (r5 == 5'd2)
                        begin
                            if (n16sp != 32'd0) d = '{M_C_ADDI16SP, 5'd2, 5'd2, 5'd0, n16sp};
                        end
                        else if (nlui != 32'd0)
                            d = '{M_C_LUI, r5, 5'd0, 5'd0, nlui};
                    end
                    3'd4:
                    begin
                        case (c[11:10])
                            2'd0: d = '{M_C_SRLI, rp1, rp1, 5'd0, sh6};
                            2'd1: d = '{M_C_SRAI, rp1, rp1, 5'd0, sh6};
                            2'd2: d = '{M_C_ANDI, rp1, rp1, 5'd0, imm6};
                            default:
                            begin
                                case ({b12, c[6:5]})
                                    3'd0: d = '{M_C_SUB, rp1, rp1, rp2, 32'd0};
                                    3'd1: d = '{M_C_XOR, rp1, rp1, rp2, 32'd0};
                                    3'd2: d = '{M_C_OR, rp1, rp1, rp2, 32'd0};
                                    3'd3: d = '{M_C_AND, rp1, rp1, rp2, 32'd0};
                                    3'd4: d = '{M_C_SUBW, rp1, rp1, rp2, 32'd0};
                                    3'd5: d = '{M_C_ADDW, rp1, rp1, rp2, 32'd0};
                                    default: d = '0;
                                endcase
                            end
                        endcase
                    end
                    3'd5: d = '{M_C_J, 5'd0, 5'd0, 5'd0, nj};
                    3'd6: d = '{M_C_BEQZ, 5'd0, rp1, 5'd0, nb};
                    default: d = '{M_C_BNEZ, 5'd0, rp1, 5'd0, nb};
                endcase
            end
            default:
            begin
                case (f3)
                    3'd0: d = '{M_C_SLLI, r5, r5, 5'd0, sh6};
                    3'd2:
                    begin
                        if (r5 != 5'd0) d = '{M_C_LWSP, r5, 5'd2, 5'd0, ulwsp};
                    end
                    3'd3:
                    begin
                        if (r5 != 5'd0) d = '{M_C_LDSP, r5, 5'd2, 5'd0, uldsp};
                    end
                    3'd4:
                    begin
                        if (!b12)
                        begin
                            if (s5 != 5'd0) d = '{M_C_MV, r5, 5'd0, s5, 32'd0};
                            else if (r5 != 5'd0) d = '{M_C_JR, 5'd0, r5, 5'd0, 32'd0};
                        end
                        else
                        begin
                            if (r5 == 5'd0 && s5 == 5'd0)
                                d = '{M_C_EBREAK, 5'd0, 5'd0, 5'd0, 32'd0};
                            else if (s5 == 5'd0)
                                d = '{M_C_JALR, 5'd1, r5, 5'd0, 32'd0};
                            else
                                d = '{M_C_ADD, r5, r5, s5, 32'd0};
                        end
                    end
                    3'd6: d = '{M_C_SWSP, 5'd0, 5'd2, s5, uswsp};
                    3'd7: d = '{M_C_SDSP, 5'd0, 5'd2, s5, usdsp};
                    default: d = '0;
                endcase
            end
        endcase
    end

endmodule

// File: rtl/core/riscv_instruction_decoder.sv
// Inputs go from the input register through the decoders into the result register.
// Throughput: one instruction per cycle; a stage advances when the stage after it has room.
// The input register and the result register each hold one transaction.
// Reset (rst_n low, asynchronous) clears both valid flags, start_reg and the pointer.
// The instruction pointer is updated in the input stage, the only feedback path with an adder.
module riscv_instruction_decoder
    import rvdec_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [12:0]          cfg_data,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  logic [31:0]          insn_word,
    input  logic                 restart,
    output logic                 out_valid,
    input  logic                 out_stall,
    output logic [12:0]          insn_address,
    output logic                 is_compressed,
    output logic [6:0]           mnemonic,
    output logic [4:0]           dest_reg,
    output logic [4:0]           src_reg_a,
    output logic [4:0]           src_reg_b,
    output logic signed [31:0]   immediate,
    output logic                 valid_res
);
    logic [ADDR_BITS-1:0] start_reg;
    logic [ADDR_BITS-1:0] ptr_reg;
    logic [ADDR_BITS-1:0] ptr_base;
    logic [ADDR_BITS-1:0] ptr_next;
    logic                 s1_valid_reg;
    logic [31:0]          s1_word_reg;
    logic [ADDR_BITS-1:0] s1_addr_reg;
    logic                 s2_valid_reg;
    logic                 s1_adv;
    logic                 s2_load;
    logic                 comp_in;
    logic                 s1_comp;
    dec_t                 d32;
    dec_t                 d16;
    dec_t                 dsel;
    dec_t                 s2_dec_reg;
    logic [ADDR_BITS-1:0] s2_addr_reg;
    logic                 s2_comp_reg;

    assign cfg_ready = 1'b1;
    assign s2_load   = !s2_valid_reg || !out_stall;
    assign s1_adv    = !s1_valid_reg || s2_load;
    assign in_stall  = !s1_adv;
    assign comp_in   = insn_word[1:0] != 2'b11;
    assign ptr_base  = restart ? start_reg : ptr_reg;
    assign ptr_next  = ptr_base + (comp_in ? ADDR_BITS'(2) : ADDR_BITS'(4));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_reg    <= '0;
            ptr_reg      <= '0;
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
                start_reg <= ADDR_BITS'(cfg_data);
            if (in_valid && !in_stall)
                ptr_reg <= ptr_next;
            if (s1_adv)
                s1_valid_reg <= in_valid;
            if (s2_load)
                s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
        begin
            s1_word_reg <= insn_word;
            s1_addr_reg <= ptr_base;
        end
        if (s2_load && s1_valid_reg)
        begin
            s2_dec_reg  <= dsel;
            s2_addr_reg <= s1_addr_reg;
            s2_comp_reg <= s1_comp;
        end
    end

    assign s1_comp = s1_word_reg[1:0] != 2'b11;

    rvdec_dec32 u_dec32 (
        .w (s1_word_reg),
        .d (d32)
    );

    rvdec_dec16 u_dec16 (
        .c (s1_word_reg[15:0]),
        .d (d16)
    );

    assign dsel = s1_comp ? d16 : d32;

    assign out_valid     = s2_valid_reg;
    assign insn_address  = 13'(s2_addr_reg);
    assign is_compressed = s2_comp_reg;
    assign mnemonic      = s2_dec_reg.mn;
    assign dest_reg      = s2_dec_reg.rd;
    assign src_reg_a     = s2_dec_reg.ra;
    assign src_reg_b     = s2_dec_reg.rb;
    assign immediate     = s2_dec_reg.imm;
    assign valid_res     = s2_dec_reg.mn != M_NONE;

endmodule

// File: rtl/core/rvdec_checker.sv
module rvdec_checker
    import rvdec_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_stall,
    input logic        out_valid,
    input logic        out_stall,
    input logic [6:0]  mnemonic,
    input logic [4:0]  dest_reg,
    input logic [31:0] immediate,
    input logic        valid_res
);
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(immediate))
        else $error("Stalled result changed.");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !valid_res |-> mnemonic == 7'd0 && dest_reg == 5'd0 && immediate == 32'd0)
        else $error("Invalid result carries nonzero fields.");

    assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> !in_stall)
        else $error("Input stalled while the pipeline has room.");

    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall ##1 !out_stall |=> out_valid)
        else $error("Accepted transaction did not reach the output.");

endmodule

bind riscv_instruction_decoder rvdec_checker u_rvdec_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .mnemonic  (mnemonic),
    .dest_reg  (dest_reg),
    .immediate (immediate),
    .valid_res (valid_res)
);
